[hdl/generational_capability_table_unit_defines.svh]
// ----------------------------------------------------------------------------
// Capability table assertion macros
// Concurrent assertion wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_CAPABILITY_TABLE_UNIT_DEFINES_SVH
`define GENERATIONAL_CAPABILITY_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/gct_pkg.sv]
// ----------------------------------------------------------------------------
// Capability table package
// Sizes, operation and status codes, slot entry layout and control types.
// ----------------------------------------------------------------------------
package gct_pkg;

   localparam int TABLE_SLOTS = 256;
   localparam int SLOT_BITS   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int FRESH_BITS  = $clog2(TABLE_SLOTS + 1);
   localparam int GEN_BITS    = 16;
   localparam logic [15:0] NO_SLOT = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_GET    = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_FULL   = 3'd1,
      ST_RANGE  = 3'd2,
      ST_EMPTY  = 3'd3,
      ST_STALE  = 3'd4,
      ST_RIGHTS = 3'd5
   } status_type;

   typedef struct packed {
      logic                used;
      logic [GEN_BITS-1:0] generation;
      logic [15:0]         link;
      logic [31:0]         object;
      logic [31:0]         rights;
      logic [31:0]         flags;
   } slot_entry_type;

   // Contents of a slot that has never been written.
   localparam slot_entry_type EMPTY_ENTRY = '{
      used:       1'b0,
      generation: GEN_BITS'(1),
      link:       16'd0,
      object:     32'd0,
      rights:     32'd0,
      flags:      32'd0
   };

   typedef enum logic {
      CTRL_IDLE,
      CTRL_EXEC
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

endpackage

[hdl/gct_ifs.sv]
// ----------------------------------------------------------------------------
// Capability table channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface gct_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] object_handle;
   logic [31:0] rights;
   logic [31:0] flags;
   logic [15:0] cap_index;
   logic [15:0] cap_gen;
   logic [31:0] needed_rights;

   modport source (
      output valid, operation, object_handle, rights, flags, cap_index, cap_gen,
             needed_rights,
      input  ready
   );
   modport sink (
      input  valid, operation, object_handle, rights, flags, cap_index, cap_gen,
             needed_rights,
      output ready
   );
endinterface

interface gct_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] result_index;
   logic [15:0] result_gen;
   logic [31:0] result_object;

   modport source (
      output valid, status, result_index, result_gen, result_object,
      input  ready
   );
   modport sink (
      input  valid, status, result_index, result_gen, result_object,
      output ready
   );
endinterface

[hdl/generational_capability_table_unit.sv]
// ----------------------------------------------------------------------------
// Generational capability table
// Fixed table of capability slots addressed by generation-checked handles.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Carries
//   req_chan  in         valid/ready    operation, object, rights, flags,
//                                       handle index/gen, required rights
//   rsp_chan  out        valid/ready    status, new index/gen, object
//
// Each request reads the slot RAM on accept, then does the check and
// write-back in the execute state once the output register is free; the
// registered read of the slot RAM sets that order.
// Reset is synchronous; ready stays low while it is high.
// No clearing pass runs, since the fresh-slot count marks which slots hold
// written data.
// The response waits in an output register; the next request is accepted
// while it waits, and its commit holds until the register is taken.
//
module generational_capability_table_unit (
   input  logic          clock,
   input  logic          reset,
   gct_req_if.sink       req_chan,
   gct_rsp_if.source     rsp_chan
);

   gct_pkg::ctrl_cmd_type cmd;

   // sequence accept, slot read and commit
   gct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // slot storage, free list and response register
   gct_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_operation      (req_chan.operation),
      .req_object_handle  (req_chan.object_handle),
      .req_rights         (req_chan.rights),
      .req_flags          (req_chan.flags),
      .req_cap_index      (req_chan.cap_index),
      .req_cap_gen        (req_chan.cap_gen),
      .req_needed_rights  (req_chan.needed_rights),
      .rsp_status         (rsp_chan.status),
      .rsp_result_index   (rsp_chan.result_index),
      .rsp_result_gen     (rsp_chan.result_gen),
      .rsp_result_object  (rsp_chan.result_object)
   );

endmodule

[hdl/gct_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/gct_ctrl.sv]
// ----------------------------------------------------------------------------
// Capability table controller
// Sequences capture, slot read and commit; owns the response valid flag.
// ----------------------------------------------------------------------------
module gct_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gct_pkg::ctrl_cmd_type cmd
);

   gct_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gct_pkg::CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         gct_pkg::CTRL_IDLE: begin
            // take no request while reset is high
            if (!reset) begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = gct_pkg::CTRL_EXEC;
               end
            end
         end
         gct_pkg::CTRL_EXEC: begin
            // hold the commit until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = gct_pkg::CTRL_IDLE;
            end
         end
         default: begin
            state_in = gct_pkg::CTRL_IDLE;
         end
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/gct_datapath.sv]
// ----------------------------------------------------------------------------
// Capability table datapath
// Slot RAM, free-list head, fresh-slot count and the response register.
// ----------------------------------------------------------------------------
module gct_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  gct_pkg::ctrl_cmd_type cmd,
   input  logic [1:0]            req_operation,
   input  logic [31:0]           req_object_handle,
   input  logic [31:0]           req_rights,
   input  logic [31:0]           req_flags,
   input  logic [15:0]           req_cap_index,
   input  logic [15:0]           req_cap_gen,
   input  logic [31:0]           req_needed_rights,
   output logic [2:0]            rsp_status,
   output logic [15:0]           rsp_result_index,
   output logic [15:0]           rsp_result_gen,
   output logic [31:0]           rsp_result_object
);

   localparam int SB = gct_pkg::SLOT_BITS;
   localparam int FB = gct_pkg::FRESH_BITS;
   localparam int GB = gct_pkg::GEN_BITS;
   localparam logic [16:0] IDX_LIMIT  = 17'(gct_pkg::TABLE_SLOTS);
   localparam logic [FB-1:0] FRESH_MAX = FB'(gct_pkg::TABLE_SLOTS);
   localparam int ENTRY_BITS = $bits(gct_pkg::slot_entry_type);

   // captured request
   gct_pkg::op_type op_ff;
   logic [31:0]     obj_ff, rts_ff, flg_ff, need_ff;
   logic [15:0]     gen_ff;
   logic [SB-1:0]   slot_ff, slot_in;
   logic            in_range_ff, in_range_in;
   logic            from_free_ff, from_free_in;
   logic            got_ff, got_in;

   // table bookkeeping
   logic [15:0]     head_ff, head_in;
   logic [FB-1:0]   fresh_ff, fresh_in;

   // response register
   logic [2:0]      status_ff, status_in;
   logic [15:0]     r_idx_ff, r_idx_in;
   logic [15:0]     r_gen_ff, r_gen_in;
   logic [31:0]     r_obj_ff, r_obj_in;

   // slot RAM
   logic [ENTRY_BITS-1:0]   rd_word;
   gct_pkg::slot_entry_type entry, wr_entry;
   logic                    wr_en;

   logic head_avail, fresh_avail;

   assign head_avail  = ({1'b0, head_ff} < IDX_LIMIT);
   assign fresh_avail = (fresh_ff < FRESH_MAX);
   assign in_range_in = ({1'b0, req_cap_index} < IDX_LIMIT);

   always_comb begin
      from_free_in = 1'b0;
      got_in       = 1'b0;
      slot_in      = req_cap_index[SB-1:0];
      if (gct_pkg::op_type'(req_operation) == gct_pkg::OP_ADD) begin
         if (head_avail) begin
            slot_in      = head_ff[SB-1:0];
            from_free_in = 1'b1;
            got_in       = 1'b1;
         end else if (fresh_avail) begin
            slot_in = fresh_ff[SB-1:0];
            got_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= gct_pkg::op_type'(req_operation);
         obj_ff       <= req_object_handle;
         rts_ff       <= req_rights;
         flg_ff       <= req_flags;
         need_ff      <= req_needed_rights;
         gen_ff       <= req_cap_gen;
         slot_ff      <= slot_in;
         in_range_ff  <= in_range_in;
         from_free_ff <= from_free_in;
         got_ff       <= got_in;
      end
   end

   gct_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (gct_pkg::TABLE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.capture),
      .rd_addr (slot_in),
      .rd_data (rd_word)
   );

   // slots at or above the fresh count were never written
   assign entry = ({{(FB-SB){1'b0}}, slot_ff} < fresh_ff) ?
                  gct_pkg::slot_entry_type'(rd_word) : gct_pkg::EMPTY_ENTRY;

   always_comb begin
      logic [GB-1:0] gen_next;
      logic          live;

      gen_next  = entry.generation + GB'(1);
      if (gen_next == '0) begin
         gen_next = GB'(1);
      end
      live      = in_range_ff && entry.used && (entry.generation == gen_ff);

      wr_en     = 1'b0;
      wr_entry  = entry;
      head_in   = head_ff;
      fresh_in  = fresh_ff;
      status_in = gct_pkg::ST_OK;
      r_idx_in  = 16'd0;
      r_gen_in  = 16'd0;
      r_obj_in  = 32'd0;

      case (op_ff)
         gct_pkg::OP_ADD: begin
            if (got_ff) begin
               wr_en           = 1'b1;
               wr_entry.used   = 1'b1;
               wr_entry.link   = gct_pkg::NO_SLOT;
               wr_entry.object = obj_ff;
               wr_entry.rights = rts_ff;
               wr_entry.flags  = flg_ff;
               r_idx_in        = 16'(slot_ff);
               r_gen_in        = entry.generation;
               if (from_free_ff) begin
                  head_in = entry.link;
               end else begin
                  fresh_in = fresh_ff + FB'(1);
               end
            end else begin
               status_in = gct_pkg::ST_FULL;
            end
         end
         gct_pkg::OP_GET, gct_pkg::OP_DELETE: begin
            if (!in_range_ff) begin
               status_in = gct_pkg::ST_RANGE;
            end else if (!entry.used) begin
               status_in = gct_pkg::ST_EMPTY;
            end else if (!live) begin
               status_in = gct_pkg::ST_STALE;
            end else if (op_ff == gct_pkg::OP_GET) begin
               if ((entry.rights & need_ff) != need_ff) begin
                  status_in = gct_pkg::ST_RIGHTS;
               end else begin
                  r_obj_in = entry.object;
               end
            end else begin
               // retire the slot and push it onto the free list
               wr_en               = 1'b1;
               wr_entry.used       = 1'b0;
               wr_entry.generation = gen_next;
               wr_entry.link       = head_ff;
               wr_entry.object     = 32'd0;
               wr_entry.rights     = 32'd0;
               wr_entry.flags      = 32'd0;
               head_in             = 16'(slot_ff);
            end
         end
         default: begin
            status_in = gct_pkg::ST_OK;
         end
      endcase

      if (!cmd.commit) begin
         wr_en    = 1'b0;
         head_in  = head_ff;
         fresh_in = fresh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= gct_pkg::NO_SLOT;
         fresh_ff <= '0;
      end else begin
         head_ff  <= head_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         r_idx_ff  <= r_idx_in;
         r_gen_ff  <= r_gen_in;
         r_obj_ff  <= r_obj_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_result_index  = r_idx_ff;
   assign rsp_result_gen    = r_gen_ff;
   assign rsp_result_object = r_obj_ff;

endmodule

[hdl/gct_checker.sv]
// ----------------------------------------------------------------------------
// Capability table checker
// Port-level assertions on sequencing and response contents.
// ----------------------------------------------------------------------------
`include "generational_capability_table_unit_defines.svh"

module gct_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_result_index,
   input logic [15:0] rsp_result_gen,
   input logic [31:0] rsp_result_object
);

   `GCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_result_index) && $stable(rsp_result_gen) && $stable(rsp_result_object), "response changed while stalled")
   `GCT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request accepted while one is in progress")
   `GCT_ASSERT_SAME(a_status_code, clock, reset, rsp_valid, rsp_status <= gct_pkg::ST_RIGHTS, "unknown status code")
   `GCT_ASSERT_SAME(a_fail_clean, clock, reset, rsp_valid && (rsp_status != gct_pkg::ST_OK), (rsp_result_index == 16'd0) && (rsp_result_gen == 16'd0) && (rsp_result_object == 32'd0), "failed response carries data")
   `GCT_ASSERT_SAME(a_rsp_source, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "response without a request two cycles before")

endmodule

bind generational_capability_table_unit gct_checker u_gct_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_result_index  (rsp_chan.result_index),
   .rsp_result_gen    (rsp_chan.result_gen),
   .rsp_result_object (rsp_chan.result_object)
);

[tb/tb_generational_capability_table_unit.sv]
// ----------------------------------------------------------------------------
// Generational capability table testbench
// Drives add, get and delete requests into the table, with unused operation
// codes, out-of-range and stale handles mixed in. Each accepted request is run
// through a behavioral copy of the table, and every response is compared
// field by field against it or a pinned script reply. The run starts with a
// short directed script, goes on with three random phases under different
// stall patterns, then fills the table, pushes past full and recycles one slot.
// ----------------------------------------------------------------------------
module tb_generational_capability_table_unit;

   // Operation code that the block must ignore.
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam int          PHASE_ITEMS  = 460;
   localparam int          DRAIN_CYCLES = 20;

   // Per-phase stall plan: sender gap and receiver stall, in percent of cycles,
   // and the share of adds in the random mix.
   localparam int TX_IDLE[3] = '{32, 78, 0};
   localparam int RX_IDLE[3] = '{78, 32, 0};
   localparam int ADD_PCT[3] = '{55, 20, 40};

   typedef struct {
      logic [1:0]  op;
      logic [31:0] object_handle;
      logic [31:0] rights;
      logic [31:0] flags;
      logic [15:0] cap_index;
      logic [15:0] cap_gen;
      logic [31:0] needed_rights;
   } cap_request_type;

   typedef struct {
      gct_pkg::status_type status;
      logic [15:0]         new_index;
      logic [15:0]         new_gen;
      logic [31:0]         found_object;
   } cap_reply_type;

   typedef struct {
      cap_request_type rq;
      bit              pinned;
      cap_reply_type   reply;
   } script_row_type;

   logic clock;
   logic reset;

   gct_req_if req_chan ();
   gct_rsp_if rsp_chan ();

   generational_capability_table_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Behavioral copy of the table.
   logic [31:0] slot_object [gct_pkg::TABLE_SLOTS];
   logic [31:0] slot_rights [gct_pkg::TABLE_SLOTS];
   logic [31:0] slot_flags  [gct_pkg::TABLE_SLOTS];
   logic [15:0] slot_gen    [gct_pkg::TABLE_SLOTS];
   logic [15:0] slot_link   [gct_pkg::TABLE_SLOTS];
   bit          slot_live   [gct_pkg::TABLE_SLOTS];
   logic [15:0] list_head;
   int          fresh_count;

   cap_reply_type  replies_due [$];
   script_row_type script [$];

   int tx_idle_pct;
   int rx_idle_pct;
   int mismatch_count;
   int response_count;

   always #5 clock = ~clock;

   // Stall the response channel at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   function automatic cap_request_type make_request(logic [1:0] op, logic [31:0] obj,
                                                    logic [31:0] rts, logic [31:0] flg,
                                                    logic [15:0] idx, logic [15:0] gen,
                                                    logic [31:0] need);
      cap_request_type rq;
      rq.op            = op;
      rq.object_handle = obj;
      rq.rights        = rts;
      rq.flags         = flg;
      rq.cap_index     = idx;
      rq.cap_gen       = gen;
      rq.needed_rights = need;
      return rq;
   endfunction

   function automatic cap_reply_type make_reply(gct_pkg::status_type st, logic [15:0] ri,
                                                logic [15:0] rg, logic [31:0] ro);
      cap_reply_type rp;
      rp.status       = st;
      rp.new_index    = ri;
      rp.new_gen      = rg;
      rp.found_object = ro;
      return rp;
   endfunction

   function automatic void plan(cap_request_type rq, bit pinned, cap_reply_type reply);
      script_row_type row;
      row.rq     = rq;
      row.pinned = pinned;
      row.reply  = reply;
      script.push_back(row);
   endfunction

   // Range, occupancy and generation check shared by get and delete.
   function automatic gct_pkg::status_type handle_status(logic [15:0] idx,
                                                         logic [15:0] gen);
      if (idx >= gct_pkg::TABLE_SLOTS) return gct_pkg::ST_RANGE;
      if (!slot_live[idx]) return gct_pkg::ST_EMPTY;
      if (slot_gen[idx] != gen) return gct_pkg::ST_STALE;
      return gct_pkg::ST_OK;
   endfunction

   // Apply one request to the table copy and return the response it must give.
   function automatic cap_reply_type apply_to_table(cap_request_type rq);
      cap_reply_type rp;
      logic [15:0]   slot;
      logic [15:0]   next_gen;
      rp   = make_reply(gct_pkg::ST_OK, '0, '0, '0);
      slot = '0;
      case (rq.op)
         gct_pkg::OP_ADD: begin
            // Reuse the most recently freed slot first, then a fresh one.
            if (list_head < gct_pkg::TABLE_SLOTS) begin
               slot      = list_head;
               list_head = slot_link[slot];
            end else if (fresh_count < gct_pkg::TABLE_SLOTS) begin
               slot = fresh_count[15:0];
               fresh_count++;
            end else begin
               rp.status = gct_pkg::ST_FULL;
            end
            if (rp.status == gct_pkg::ST_OK) begin
               slot_object[slot] = rq.object_handle;
               slot_rights[slot] = rq.rights;
               slot_flags[slot]  = rq.flags;
               slot_live[slot]   = 1'b1;
               slot_link[slot]   = gct_pkg::NO_SLOT;
               rp.new_index      = slot;
               rp.new_gen        = slot_gen[slot];
            end
         end
         gct_pkg::OP_GET: begin
            rp.status = handle_status(rq.cap_index, rq.cap_gen);
            if (rp.status == gct_pkg::ST_OK) begin
               if ((slot_rights[rq.cap_index] & rq.needed_rights) != rq.needed_rights)
                  rp.status = gct_pkg::ST_RIGHTS;
               else
                  rp.found_object = slot_object[rq.cap_index];
            end
         end
         gct_pkg::OP_DELETE: begin
            rp.status = handle_status(rq.cap_index, rq.cap_gen);
            if (rp.status == gct_pkg::ST_OK) begin
               slot     = rq.cap_index;
               // Advance the generation, never landing on zero.
               next_gen = slot_gen[slot] + 16'd1;
               if (next_gen == 16'd0) next_gen = 16'd1;
               slot_object[slot] = '0;
               slot_rights[slot] = '0;
               slot_flags[slot]  = '0;
               slot_live[slot]   = 1'b0;
               slot_gen[slot]    = next_gen;
               slot_link[slot]   = list_head;
               list_head         = slot;
            end
         end
         default: begin
            // Unused code: no change, all-zero response.
         end
      endcase
      return rp;
   endfunction

   // Draw one random request. Most get and delete handles point into the used
   // part of the table with the live generation; the rest are stale or random.
   function automatic cap_request_type pick_request(int add_pct);
      cap_request_type rq;
      int              roll;
      rq = make_request(gct_pkg::OP_ADD, $urandom, $urandom, $urandom,
                        16'($urandom), 16'($urandom), $urandom);
      if (fresh_count > 0 && $urandom_range(7) != 0) begin
         rq.cap_index = 16'($urandom_range(fresh_count - 1));
         case ($urandom_range(9))
            0: rq.cap_gen = slot_gen[rq.cap_index] - 16'd1;
            1: ;
            default: rq.cap_gen = slot_gen[rq.cap_index];
         endcase
      end
      roll = $urandom_range(99);
      if (roll < add_pct) begin
         rq.op = gct_pkg::OP_ADD;
         if ($urandom_range(15) == 0) rq.object_handle = '0;
         if ($urandom_range(7) == 0) rq.rights = '1;
      end else if (roll < add_pct + 30) begin
         rq.op = gct_pkg::OP_GET;
         case ($urandom_range(3))
            0, 1: rq.needed_rights =
                     slot_rights[rq.cap_index[gct_pkg::SLOT_BITS-1:0]] & $urandom;
            2: rq.needed_rights = '0;
            default: ;
         endcase
      end else if (roll < 95) begin
         rq.op = gct_pkg::OP_DELETE;
      end else begin
         // Noise: any code, with the random fields drawn above.
         rq.op = 2'($urandom_range(3));
      end
      return rq;
   endfunction

   // Present one request, hold it until taken, then log the response it owes.
   task automatic send_request(cap_request_type rq, bit pinned, cap_reply_type fixed);
      cap_reply_type predicted;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.operation     <= rq.op;
      req_chan.object_handle <= rq.object_handle;
      req_chan.rights        <= rq.rights;
      req_chan.flags         <= rq.flags;
      req_chan.cap_index     <= rq.cap_index;
      req_chan.cap_gen       <= rq.cap_gen;
      req_chan.needed_rights <= rq.needed_rights;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = apply_to_table(rq);
      if (pinned)
         replies_due.push_back(fixed);
      else
         replies_due.push_back(predicted);
   endtask

   // Drop valid and hold off until every owed response has come back.
   task automatic wait_for_quiet();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (replies_due.size() != 0);
   endtask

   task automatic flag_mismatch(string what);
      $display("mismatch at %0t, response %0d: %s", $time, response_count, what);
      mismatch_count++;
   endtask

   // Compare each response taken against the oldest owed one.
   always @(posedge clock) begin : check_response
      cap_reply_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (replies_due.size() == 0) begin
            flag_mismatch("response with no request outstanding");
         end else begin
            want = replies_due.pop_front();
            if (rsp_chan.status !== want.status)
               flag_mismatch($sformatf("status %0d, expected %0d",
                                       rsp_chan.status, want.status));
            if (rsp_chan.result_index !== want.new_index)
               flag_mismatch($sformatf("result_index %0d, expected %0d",
                                       rsp_chan.result_index, want.new_index));
            if (rsp_chan.result_gen !== want.new_gen)
               flag_mismatch($sformatf("result_gen %0d, expected %0d",
                                       rsp_chan.result_gen, want.new_gen));
            if (rsp_chan.result_object !== want.found_object)
               flag_mismatch($sformatf("result_object %h, expected %h",
                                       rsp_chan.result_object, want.found_object));
         end
         response_count++;
      end
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      cap_reply_type   unused_reply;
      cap_request_type rq;
      int              spare_slot;
      logic [15:0]     old_gen;

      // Hold every input at a known value from time zero.
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.operation     = '0;
      req_chan.object_handle = '0;
      req_chan.rights        = '0;
      req_chan.flags         = '0;
      req_chan.cap_index     = '0;
      req_chan.cap_gen       = '0;
      req_chan.needed_rights = '0;
      rsp_chan.ready         = 1'b0;
      mismatch_count         = 0;
      response_count         = 0;
      tx_idle_pct            = TX_IDLE[0];
      rx_idle_pct            = RX_IDLE[0];

      // Table copy after reset: all empty, generation one, free list empty.
      for (int i = 0; i < gct_pkg::TABLE_SLOTS; i++) begin
         slot_object[i] = '0;
         slot_rights[i] = '0;
         slot_flags[i]  = '0;
         slot_gen[i]    = 16'd1;
         slot_link[i]   = '0;
         slot_live[i]   = 1'b0;
      end
      list_head    = gct_pkg::NO_SLOT;
      fresh_count  = 0;
      unused_reply = make_reply(gct_pkg::ST_OK, '0, '0, '0);

      // Directed script. Lookups and deletes on an empty table and out of range.
      plan(make_request(gct_pkg::OP_GET, 32'd1, '0, '0, 16'd0, 16'd1, '0), 1,
           make_reply(gct_pkg::ST_EMPTY, '0, '0, '0));
      plan(make_request(gct_pkg::OP_GET, 32'd1, '0, '0, 16'd256, 16'd1, '0), 1,
           make_reply(gct_pkg::ST_RANGE, '0, '0, '0));
      plan(make_request(gct_pkg::OP_DELETE, '1, '1, '1, 16'hFFFF, 16'hFFFF, '1), 1,
           make_reply(gct_pkg::ST_RANGE, '0, '0, '0));
      // Fresh slots are handed out in order with generation one.
      plan(make_request(gct_pkg::OP_ADD, '1, '1, '1, '0, '0, '0), 1,
           make_reply(gct_pkg::ST_OK, 16'd0, 16'd1, '0));
      plan(make_request(gct_pkg::OP_ADD, '0, '0, '0, '0, '0, '0), 1,
           make_reply(gct_pkg::ST_OK, 16'd1, 16'd1, '0));
      plan(make_request(gct_pkg::OP_ADD, 32'd1, 32'h0000_00A5, 32'h5A5A_5A5A, '1, '1, '1),
           1, make_reply(gct_pkg::ST_OK, 16'd2, 16'd1, '0));
      // Lookups: full rights, a zero object, missing and present rights bits.
      plan(make_request(gct_pkg::OP_GET, '0, '0, '0, 16'd0, 16'd1, '1), 1,
           make_reply(gct_pkg::ST_OK, '0, '0, '1));
      plan(make_request(gct_pkg::OP_GET, '1, '1, '1, 16'd1, 16'd1, '0), 1,
           make_reply(gct_pkg::ST_OK, '0, '0, '0));
      plan(make_request(gct_pkg::OP_GET, '0, '0, '0, 16'd1, 16'd1, 32'd1), 1,
           make_reply(gct_pkg::ST_RIGHTS, '0, '0, '0));
      plan(make_request(gct_pkg::OP_GET, '0, '0, '0, 16'd2, 16'd1, 32'h24), 1,
           make_reply(gct_pkg::ST_OK, '0, '0, 32'd1));
      plan(make_request(gct_pkg::OP_GET, '0, '0, '0, 16'd2, 16'd1, 32'h02), 1,
           make_reply(gct_pkg::ST_RIGHTS, '0, '0, '0));
      // Wrong generations on a live slot.
      plan(make_request(gct_pkg::OP_GET, '0, '0, '0, 16'd0, 16'hFFFF, '0), 1,
           make_reply(gct_pkg::ST_STALE, '0, '0, '0));
      plan(make_request(gct_pkg::OP_GET, '0, '0, '0, 16'd0, 16'd0, '0), 1,
           make_reply(gct_pkg::ST_STALE, '0, '0, '0));
      plan(make_request(gct_pkg::OP_DELETE, '0, '0, '0, 16'd2, 16'd2, '0), 1,
           make_reply(gct_pkg::ST_STALE, '0, '0, '0));
      // Delete, then the dead handle must read as empty.
      plan(make_request(gct_pkg::OP_DELETE, '0, '0, '0, 16'd1, 16'd1, '0), 1,
           make_reply(gct_pkg::ST_OK, '0, '0, '0));
      plan(make_request(gct_pkg::OP_GET, '0, '0, '0, 16'd1, 16'd1, '0), 1,
           make_reply(gct_pkg::ST_EMPTY, '0, '0, '0));
      plan(make_request(gct_pkg::OP_DELETE, '0, '0, '0, 16'd1, 16'd2, '0), 1,
           make_reply(gct_pkg::ST_EMPTY, '0, '0, '0));
      plan(make_request(gct_pkg::OP_DELETE, '0, '0, '0, 16'd0, 16'd1, '0), 1,
           make_reply(gct_pkg::ST_OK, '0, '0, '0));
      // Freed slots come back last-in first-out with the next generation.
      plan(make_request(gct_pkg::OP_ADD, 32'h8000_0000, '0, '1, '0, '0, '0), 1,
           make_reply(gct_pkg::ST_OK, 16'd0, 16'd2, '0));
      plan(make_request(gct_pkg::OP_ADD, 32'h7FFF_FFFF, '1, '0, '0, '0, '0), 1,
           make_reply(gct_pkg::ST_OK, 16'd1, 16'd2, '0));
      plan(make_request(gct_pkg::OP_ADD, 32'h1234_5678, 32'hF0F0_F0F0, '0, '0, '0, '0), 1,
           make_reply(gct_pkg::ST_OK, 16'd3, 16'd1, '0));
      // Unused code with every field set: no effect, all-zero response.
      plan(make_request(OP_UNUSED, '1, '1, '1, '1, '1, '1), 1,
           make_reply(gct_pkg::ST_OK, '0, '0, '0));
      plan(make_request(gct_pkg::OP_GET, '0, '0, '0, 16'd3, 16'd1, 32'h3000_0F00), 0,
           unused_reply);
      plan(make_request(gct_pkg::OP_DELETE, '0, '0, '0, 16'd255, 16'd1, '0), 1,
           make_reply(gct_pkg::ST_EMPTY, '0, '0, '0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_request(script[i].rq, script[i].pinned, script[i].reply);

      // Random phases; drain fully at each boundary before the stall plan changes.
      for (int ph = 0; ph < 3; ph++) begin
         wait_for_quiet();
         tx_idle_pct = TX_IDLE[ph];
         rx_idle_pct = RX_IDLE[ph];
         repeat (PHASE_ITEMS) send_request(pick_request(ADD_PCT[ph]), 0, unused_reply);
      end

      // Fill the table, then push past full.
      while (list_head != gct_pkg::NO_SLOT || fresh_count < gct_pkg::TABLE_SLOTS) begin
         rq    = pick_request(100);
         rq.op = gct_pkg::OP_ADD;
         send_request(rq, 0, unused_reply);
      end
      repeat (3) send_request(pick_request(100), 0, unused_reply);

      // Free one slot of the full table, take it back, then probe both handles.
      spare_slot = $urandom_range(gct_pkg::TABLE_SLOTS - 1);
      old_gen    = slot_gen[spare_slot];
      send_request(make_request(gct_pkg::OP_DELETE, $urandom, $urandom, $urandom,
                                16'(spare_slot), old_gen, $urandom), 0, unused_reply);
      rq    = pick_request(100);
      rq.op = gct_pkg::OP_ADD;
      send_request(rq, 0, unused_reply);
      send_request(make_request(gct_pkg::OP_GET, '0, '0, '0, 16'(spare_slot), old_gen,
                                '0), 0, unused_reply);
      send_request(make_request(gct_pkg::OP_GET, '0, '0, '0, 16'(spare_slot),
                                slot_gen[spare_slot], '0), 0, unused_reply);

      // Drain, then give the block time to show any stray response.
      wait_for_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
